/* rtl/gpio_pkg.sv */
// Shared types and constants of the GPIO port with edge interrupts.
// Word layouts, register offsets, item kinds and edge-type codes.
// No dependencies.
package gpio_pkg;

    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_SAMPLE = 2'd2,
        KIND_IDLE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        EDGE_FALL = 2'b00,
        EDGE_RISE = 2'b01,
        EDGE_BOTH = 2'b10,
        EDGE_NONE = 2'b11
    } t_edge;

    localparam logic [3:0] ADDR_DIR      = 4'd0;
    localparam logic [3:0] ADDR_ENABLE   = 4'd1;
    localparam logic [3:0] ADDR_INPUT    = 4'd2;
    localparam logic [3:0] ADDR_OUTPUT   = 4'd3;
    localparam logic [3:0] ADDR_OUT_SET  = 4'd4;
    localparam logic [3:0] ADDR_OUT_CLR  = 4'd5;
    localparam logic [3:0] ADDR_IRQ_EN   = 4'd6;
    localparam logic [3:0] ADDR_EDGE_LO  = 4'd7;
    localparam logic [3:0] ADDR_EDGE_HI  = 4'd8;
    localparam logic [3:0] ADDR_STATUS   = 4'd9;
    localparam logic [3:0] ADDR_PADCFG0  = 4'd10;
    localparam logic [3:0] ADDR_PADCFG1  = 4'd11;
    localparam logic [3:0] ADDR_PADCFG2  = 4'd12;
    localparam logic [3:0] ADDR_PADCFG3  = 4'd13;

    // pad-config words sit at offsets 10..13; index = offset - 10 (mod 4)
    localparam logic [1:0] PADCFG_BASE_LSB = 2'd2;

    localparam int unsigned PINS_PER_EDGE_WORD = 16;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  address;
        logic [31:0] write_data;
        logic [31:0] pad_sample;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] pad_drive;
        logic [31:0] pad_output_enable;
        logic        irq;
    } t_rsp;

endpackage

/* rtl/gpio_if.sv */
// Valid/ready channel interfaces of the GPIO port: request and response.
// Depends on gpio_pkg for the word layouts.
interface gpio_req_if;
    logic              valid;
    logic              ready;
    gpio_pkg::t_req    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gpio_rsp_if;
    logic              valid;
    logic              ready;
    gpio_pkg::t_rsp    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/gpio_edge.sv */
// Per-pin edge detector of the GPIO port.
// Depends on gpio_pkg for the edge-type codes.
module gpio_edge (
    input  logic [31:0] i_last,
    input  logic [31:0] i_now,
    input  logic [31:0] i_armed,
    input  logic [31:0] i_edge_lo,
    input  logic [31:0] i_edge_hi,
    output logic [31:0] o_hits
);

    logic [63:0] w_types;

    assign w_types = {i_edge_hi, i_edge_lo};

    always_comb begin
        o_hits = '0;
        for (int p = 0; p < 32; p++) begin
            if (i_armed[p]) begin
                case (gpio_pkg::t_edge'(w_types[2*p +: 2]))
                    gpio_pkg::EDGE_FALL: o_hits[p] = i_last[p] & ~i_now[p];
                    gpio_pkg::EDGE_RISE: o_hits[p] = ~i_last[p] & i_now[p];
                    gpio_pkg::EDGE_BOTH: o_hits[p] = i_last[p] ^ i_now[p];
                    default:             o_hits[p] = 1'b0;
                endcase
            end
        end
    end

endmodule

/* rtl/gpio_regs.sv */
// Register file of the GPIO port: state, bus decode and result word.
// Depends on gpio_pkg and gpio_edge.
module gpio_regs #(
    parameter int PIN_COUNT = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  gpio_pkg::t_req i_req,
    output gpio_pkg::t_rsp o_rsp
);

    localparam logic [31:0] PIN_MASK = 32'((64'd1 << PIN_COUNT) - 64'd1);

    logic [31:0] r_dir, n_dir;
    logic [31:0] r_en, n_en;
    logic [31:0] r_last, n_last;
    logic [31:0] r_out, n_out;
    logic [31:0] r_ie, n_ie;
    logic [31:0] r_edge_lo, n_edge_lo;
    logic [31:0] r_edge_hi, n_edge_hi;
    logic [31:0] r_status, n_status;
    logic [31:0] r_padcfg [4];

    logic        w_rd, w_wr, w_smp;
    logic [1:0]  w_cfg_idx;
    logic [31:0] w_now, w_hits, w_rdata;

    assign w_rd      = (i_req.kind == gpio_pkg::KIND_READ);
    assign w_wr      = (i_req.kind == gpio_pkg::KIND_WRITE);
    assign w_smp     = (i_req.kind == gpio_pkg::KIND_SAMPLE);
    assign w_cfg_idx = i_req.address[1:0] - gpio_pkg::PADCFG_BASE_LSB;
    assign w_now     = i_req.pad_sample & PIN_MASK;

    gpio_edge u_edge (
        .i_last    (r_last),
        .i_now     (w_now),
        .i_armed   (r_en & r_ie & PIN_MASK),
        .i_edge_lo (r_edge_lo),
        .i_edge_hi (r_edge_hi),
        .o_hits    (w_hits)
    );

    always_comb begin
        w_rdata = '0;
        case (i_req.address)
            gpio_pkg::ADDR_DIR:     w_rdata = r_dir;
            gpio_pkg::ADDR_ENABLE:  w_rdata = r_en;
            gpio_pkg::ADDR_INPUT:   w_rdata = r_last;
            gpio_pkg::ADDR_OUTPUT:  w_rdata = r_out;
            gpio_pkg::ADDR_IRQ_EN:  w_rdata = r_ie;
            gpio_pkg::ADDR_EDGE_LO: w_rdata = r_edge_lo;
            gpio_pkg::ADDR_EDGE_HI: w_rdata = r_edge_hi;
            gpio_pkg::ADDR_STATUS:  w_rdata = r_status;
            gpio_pkg::ADDR_PADCFG0, gpio_pkg::ADDR_PADCFG1,
            gpio_pkg::ADDR_PADCFG2, gpio_pkg::ADDR_PADCFG3:
                                    w_rdata = r_padcfg[w_cfg_idx];
            default:                w_rdata = '0;
        endcase
        if (!w_rd) begin
            w_rdata = '0;
        end
    end

    always_comb begin
        n_dir     = r_dir;
        n_en      = r_en;
        n_last    = r_last;
        n_out     = r_out;
        n_ie      = r_ie;
        n_edge_lo = r_edge_lo;
        n_edge_hi = r_edge_hi;
        n_status  = r_status;
        if (w_wr) begin
            case (i_req.address)
                gpio_pkg::ADDR_DIR:     n_dir = i_req.write_data & PIN_MASK;
                gpio_pkg::ADDR_ENABLE:  n_en  = i_req.write_data & PIN_MASK;
                gpio_pkg::ADDR_OUTPUT:  n_out = i_req.write_data & PIN_MASK;
                gpio_pkg::ADDR_OUT_SET: n_out = (r_out | i_req.write_data) & PIN_MASK;
                gpio_pkg::ADDR_OUT_CLR: n_out = r_out & ~i_req.write_data & PIN_MASK;
                gpio_pkg::ADDR_IRQ_EN:  n_ie  = i_req.write_data & PIN_MASK;
                gpio_pkg::ADDR_EDGE_LO: n_edge_lo = i_req.write_data;
                gpio_pkg::ADDR_EDGE_HI: n_edge_hi = i_req.write_data;
                default: ;
            endcase
        end
        if (w_rd && i_req.address == gpio_pkg::ADDR_STATUS) begin
            n_status = '0;
        end
        if (w_smp) begin
            n_status = r_status | w_hits;
            n_last   = w_now;
        end
    end

    always_comb begin
        o_rsp.read_data         = w_rdata;
        o_rsp.pad_drive         = n_out;
        o_rsp.pad_output_enable = n_dir;
        o_rsp.irq               = |n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir     <= '0;
            r_en      <= '0;
            r_last    <= '0;
            r_out     <= '0;
            r_ie      <= '0;
            r_edge_lo <= '0;
            r_edge_hi <= '0;
            r_status  <= '0;
        end else if (i_step) begin
            r_dir     <= n_dir;
            r_en      <= n_en;
            r_last    <= n_last;
            r_out     <= n_out;
            r_ie      <= n_ie;
            r_edge_lo <= n_edge_lo;
            r_edge_hi <= n_edge_hi;
            r_status  <= n_status;
        end
    end

    // pad-config words are plain storage, reset to zero like the rest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_padcfg[k] <= '0;
            end
        end else if (i_step && w_wr && i_req.address >= gpio_pkg::ADDR_PADCFG0
                     && i_req.address <= gpio_pkg::ADDR_PADCFG3) begin
            r_padcfg[w_cfg_idx] <= i_req.write_data;
        end
    end

endmodule

/* rtl/gpio_port_with_edge_interrupts.sv */
// GPIO port with edge interrupts, top level: input register, register file, result register.
// An accepted request word waits in the request register, then passes through the register
// file into the result register, where the sink takes it.
// Throughput: one word per cycle while the sink takes results; the request and result
// registers advance together, so a new word enters while the previous result waits.
// Reset (i_rst_n, synchronous, active low) clears the port state and both valid flags;
// the held request and result words are not reset.
// Depends on gpio_pkg, gpio_if, gpio_regs and gpio_edge.
module gpio_port_with_edge_interrupts #(
    parameter int PIN_COUNT = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gpio_req_if.sink          i_req,
    gpio_rsp_if.source        o_rsp
);

    localparam logic [31:0] PIN_MASK = 32'((64'd1 << PIN_COUNT) - 64'd1);

    // Request register: holds the word until the register file processes it.
    logic           r_in_valid;
    gpio_pkg::t_req r_in;

    // Result register: holds the response word until the sink takes it.
    logic           r_out_valid;
    gpio_pkg::t_rsp r_out;

    logic           w_step;
    logic           w_in_ready;
    gpio_pkg::t_rsp w_result;

    // Advance when a request is held and the result slot is free or draining.
    assign w_step     = r_in_valid && (!r_out_valid || o_rsp.ready);
    // Accept a new word whenever the request register empties this cycle.
    assign w_in_ready = !r_in_valid || w_step;

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_req.valid) begin
            r_in <= i_req.data;
        end
    end

    // State update and result formation happen in one pass on w_step.
    gpio_regs #(
        .PIN_COUNT (PIN_COUNT)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_req   (r_in),
        .o_rsp   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the result word only on advance; hold it while stalled.
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    // A processed word always lands in the result register.
    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("processed word did not reach result register");

    // Input stalls only when both registers are full and the sink holds off.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_ready |-> (r_in_valid && r_out_valid && !o_rsp.ready))
        else $error("input stalled without cause");

    // A status read clears status, so its response reports no interrupt.
    a_status_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in.kind == gpio_pkg::KIND_READ
         && r_in.address == gpio_pkg::ADDR_STATUS) |=> !r_out.irq)
        else $error("irq still set after status read");

    // Pins beyond the port width never drive.
    a_pin_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.pad_output_enable & ~PIN_MASK) == '0
                         && (r_out.pad_drive & ~PIN_MASK) == '0))
        else $error("unused pin bits set");

endmodule
